// File: sv/des_block_cipher_unit_macros.svh
// assertion macros for the des block cipher unit
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef DES_BLOCK_CIPHER_UNIT_MACROS_SVH
`define DES_BLOCK_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DBC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define DBC_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("%m failed");
`else
`define DBC_ASSERT_IMPL(label, clk, rst, prop)
`define DBC_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

// File: sv/dbc_pkg.sv
// shared types, tables and permutation functions for the des unit
// no dependencies
package dbc_pkg;
   localparam int RoundCount = 16;
   localparam logic [4:0] LAST_ROUND = 5'd15;

   typedef struct packed {
      logic load;
      logic round;
      logic finish;
      logic decrypt;
      logic [3:0] index;
   } dp_cmd_type;

   typedef logic [3:0] sbox_row_type [0:63];

   localparam logic [7:0] TAB_IP [0:63] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam logic [7:0] TAB_FP [0:63] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam logic [7:0] TAB_E [0:47] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam logic [7:0] TAB_P [0:31] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam logic [7:0] TAB_PC1 [0:55] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam logic [7:0] TAB_PC2 [0:47] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam logic [1:0] TAB_ROT [0:15] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam logic [3:0] TAB_S [0:7][0:63] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
     0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
     4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
     15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
     3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
     0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
     13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
     13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
     13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
     1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
     13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
     10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
     3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
     14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
     4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
     11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
     10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
     9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
     4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
     13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
     1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
     6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
     1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
     7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
     2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] perm_ip(input logic [63:0] src);
      logic [63:0] res;
      for (int i = 0; i < 64; i++) res[63-i] = src[64-int'(TAB_IP[i])];
      return res;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] src);
      logic [63:0] res;
      for (int i = 0; i < 64; i++) res[63-i] = src[64-int'(TAB_FP[i])];
      return res;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] src);
      logic [55:0] res;
      for (int i = 0; i < 56; i++) res[55-i] = src[64-int'(TAB_PC1[i])];
      return res;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] src);
      logic [47:0] res;
      for (int i = 0; i < 48; i++) res[47-i] = src[56-int'(TAB_PC2[i])];
      return res;
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [5:0] six;
      logic [31:0] s;
      logic [31:0] res;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TAB_E[i])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[42-6*i +: 6];
         s[28-4*i +: 4] = TAB_S[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) res[31-i] = s[32-int'(TAB_P[i])];
      return res;
   endfunction
endpackage

// File: sv/dbc_key_schedule.sv
// round key store: expands the written key value into sixteen round keys
// depends on dbc_pkg
module dbc_key_schedule (
   input  logic        clock,
   input  logic        reset,
   input  logic        key_write,
   input  logic [63:0] key_value,
   input  logic [3:0]  index,
   output logic [47:0] round_key
);
   logic [47:0] keys_ff [0:15];
   logic [47:0] keys_in [0:15];
   logic [27:0] c;
   logic [27:0] d;
   logic [55:0] cd;

   // whole schedule is rebuilt on a key write; only narrow rotates chain
   always_comb begin
      cd = dbc_pkg::perm_pc1(key_value);
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 16; i++) begin
         if (dbc_pkg::TAB_ROT[i] == 2'd1) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
         end
         keys_in[i] = dbc_pkg::perm_pc2({c, d});
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         if (reset) begin
            keys_ff[i] <= '0;
         end else if (key_write) begin
            keys_ff[i] <= keys_in[i];
         end
      end
   end

   assign round_key = keys_ff[index];
endmodule

// File: sv/dbc_datapath.sv
// feistel datapath: ip, shared round unit, swap and fp
// depends on dbc_pkg and dbc_key_schedule
`include "des_block_cipher_unit_macros.svh"
module dbc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  dbc_pkg::dp_cmd_type cmd,
   input  logic [63:0]        data_block,
   input  logic               key_write,
   input  logic [63:0]        key_value,
   output logic [63:0]        result_block
);
   logic [31:0] l_ff, l_in, r_ff, r_in;
   logic [63:0] res_ff, res_in;
   logic [47:0] round_key;
   logic [3:0]  key_index;
   logic [63:0] ip_block;

   assign key_index = cmd.decrypt ? (4'd15 - cmd.index) : cmd.index;

   dbc_key_schedule u_keys (
      .clock     (clock),
      .reset     (reset),
      .key_write (key_write),
      .key_value (key_value),
      .index     (key_index),
      .round_key (round_key)
   );

   always_comb begin
      ip_block = dbc_pkg::perm_ip(data_block);
      l_in = l_ff;
      r_in = r_ff;
      res_in = res_ff;
      if (cmd.load) begin
         l_in = ip_block[63:32];
         r_in = ip_block[31:0];
      end else if (cmd.round) begin
         l_in = r_ff;
         r_in = l_ff ^ dbc_pkg::round_f(r_ff, round_key);
      end
      if (cmd.finish) begin
         res_in = dbc_pkg::perm_fp({r_ff, l_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_ff <= '0;
         r_ff <= '0;
         res_ff <= '0;
      end else begin
         l_ff <= l_in;
         r_ff <= r_in;
         res_ff <= res_in;
      end
   end

   assign result_block = res_ff;

   `DBC_ASSERT_IMPL(a_cmd_excl, clock, reset, !(cmd.load && cmd.round))
   `DBC_ASSERT_IMPL(a_finish_excl, clock, reset, !(cmd.finish && (cmd.load || cmd.round)))
   `DBC_ASSERT_NEXT(a_res_hold, clock, reset, !cmd.finish, $stable(res_ff))
endmodule

// File: sv/dbc_controller.sv
// round sequencer for the des unit
// depends on dbc_pkg
`include "des_block_cipher_unit_macros.svh"
module dbc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               decrypt,
   output logic               busy,
   output logic               done,
   output dbc_pkg::dp_cmd_type cmd
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic       dec_ff, dec_in;
   logic       done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      dec_in = dec_ff;
      done_in = 1'b0;
      cmd = '0;
      cmd.decrypt = dec_ff;
      cmd.index = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               dec_in = decrypt;
               count_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            count_in = count_ff + 4'd1;
            if ({1'b0, count_ff} == dbc_pkg::LAST_ROUND) state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.finish = 1'b1;
            done_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         dec_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dec_ff <= dec_in;
         done_ff <= done_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = done_ff;

   `DBC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `DBC_ASSERT_NEXT(a_done_after_out, clock, reset, state_ff == ST_OUT, done && !busy)
   `DBC_ASSERT_IMPL(a_count_idle, clock, reset, !(state_ff == ST_OUT && count_ff != 4'd0))
endmodule

// File: sv/des_block_cipher_unit.sv
// des block cipher unit: single-des, one round per cycle
// csr key register at byte address 0, 64-bit data
// req channel: start with req_data_block and req_decrypt, accepted when busy is low
// rsp channel: rsp_valid strobes one cycle with rsp_result_block; no back-pressure
// sequence: ip on acceptance, the rounds in ST_ROUND, then fp in ST_OUT; rsp_valid is registered with the result
// a new block is accepted only once the previous result is registered, set by the single shared round unit
// busy stays high from acceptance until the result has been registered
// the sixteen round keys are rebuilt in the cycle of a key write
// reset clears the key to zero and returns the sequencer to idle
// write the key only while busy is low and no response is pending
// the receiver cannot stall; a result shows for exactly one cycle
module des_block_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_data_block,
   input  logic        req_decrypt,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_block,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] ADDR_KEY = 3'd0;

   dbc_pkg::dp_cmd_type cmd;
   logic [63:0] key_ff, key_in;
   logic        key_write;

   assign csr_pready = 1'b1;
   assign key_write = csr_psel && csr_penable && csr_pwrite && (csr_paddr == ADDR_KEY);
   assign key_in = key_write ? csr_pwdata : key_ff;
   assign csr_prdata = (csr_paddr == ADDR_KEY) ? key_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) key_ff <= '0;
      else       key_ff <= key_in;
   end

   dbc_controller u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .decrypt (req_decrypt),
      .busy    (busy),
      .done    (rsp_valid),
      .cmd     (cmd)
   );

   dbc_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .data_block   (req_data_block),
      .key_write    (key_write),
      .key_value    (csr_pwdata),
      .result_block (rsp_result_block)
   );
endmodule

// File: dv/des_block_cipher_unit_test.sv
// self-checking testbench for the des block cipher unit: directed table, then random blocks
// depends on dbc_pkg (round count, s-boxes) and des_block_cipher_unit
module des_block_cipher_unit_test;
   localparam int MaxIdle = 4000;
   localparam logic [2:0] KEY_ADDR = 3'd0;

   typedef struct {
      logic [63:0] blk;
      logic        dec;
      logic        known;
      logic [63:0] want;
   } vec_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [63:0] req_data_block = '0;
   logic        req_decrypt = 0;
   logic        rsp_valid;
   logic [63:0] rsp_result_block;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   logic [63:0] cipher_key;
   logic [47:0] sched [0:15];
   logic [63:0] pending_blocks [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_idle = 0;
   bit          done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   des_block_cipher_unit DUT (.*);

   function automatic logic [63:0] init_perm(logic [63:0] s);
      logic [63:0] r;
      int src;
      for (int i = 0; i < 64; i++) begin
         src = (i < 32) ? 58 + 2 * (i / 8) - 8 * (i % 8) : 57 + 2 * ((i - 32) / 8) - 8 * (i % 8);
         r[63-i] = s[64-src];
      end
      return r;
   endfunction

   function automatic logic [63:0] inv_perm(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] probe;
      logic [63:0] moved;
      r = '0;
      for (int j = 0; j < 64; j++) begin
         probe = 64'd1 << (63 - j);
         moved = init_perm(probe);
         for (int i = 0; i < 64; i++)
            if (moved[63-i]) r[63-j] = s[63-i];
      end
      return r;
   endfunction

   function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
      localparam int PT [0:31] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
                                   2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
      logic [47:0] x;
      logic [5:0]  six;
      logic [31:0] s, res;
      for (int g = 0; g < 8; g++)
         for (int b = 0; b < 6; b++)
            x[47-6*g-b] = r[31 - ((4*g + b - 1 + 32) % 32)];
      x = x ^ k;
      for (int g = 0; g < 8; g++) begin
         six = x[42-6*g +: 6];
         s[28-4*g +: 4] = dbc_pkg::TAB_S[g][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) res[31-i] = s[32-PT[i]];
      return res;
   endfunction

   function automatic void build_schedule(logic [63:0] k);
      localparam int PC1 [0:55] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,
         10,2,59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,
         7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
      localparam int PC2 [0:47] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,
         16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,
         46,42,50,36,29,32};
      logic [27:0] c, d;
      logic [55:0] cd;
      for (int i = 0; i < 56; i++) cd[55-i] = k[64-PC1[i]];
      c = cd[55:28];
      d = cd[27:0];
      for (int rnd = 0; rnd < dbc_pkg::RoundCount; rnd++) begin
         for (int n = 0; n < ((rnd < 2 || rnd == 8 || rnd == 15) ? 1 : 2); n++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         cd = {c, d};
         for (int i = 0; i < 48; i++) sched[rnd][47-i] = cd[56-PC2[i]];
      end
   endfunction

   function automatic logic [63:0] des_block(logic [63:0] blk, logic dec);
      logic [63:0] b;
      logic [31:0] l, r, t;
      b = init_perm(blk);
      l = b[63:32];
      r = b[31:0];
      for (int i = 0; i < dbc_pkg::RoundCount; i++) begin
         t = r;
         r = l ^ feistel(r, sched[dec ? 15 - i : i]);
         l = t;
      end
      return inv_perm({r, l});
   endfunction

   task automatic write_key(logic [63:0] k);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= KEY_ADDR; csr_pwdata <= k;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      cipher_key = k;
      build_schedule(k);
   endtask

   task automatic send_block(logic [63:0] blk, logic dec, logic known, logic [63:0] want);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clock);
      start <= 1;
      req_data_block <= blk;
      req_decrypt <= dec;
      do @(posedge clock); while (busy);
      pending_blocks.push_back(known ? want : des_block(blk, dec));
      start <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            idle_cycles <= 0;
            if (pending_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %h", rsp_result_block);
            end else begin
               if (rsp_result_block !== pending_blocks[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h got %h", pending_blocks[0],
                              rsp_result_block);
               end
               void'(pending_blocks.pop_front());
            end
         end else if (start && !busy) begin
            idle_cycles <= 0;
         end else if (!done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= MaxIdle) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   vec_type directed [$];

   initial begin
      logic [63:0] k;
      repeat (2) @(posedge clock);
      reset <= 0;
      build_schedule(64'd0);

      // all-zero key: schedule is zero
      directed.push_back('{64'h0, 0, 0, 64'h0});
      directed.push_back('{64'hffff_ffff_ffff_ffff, 0, 0, 64'h0});
      directed.push_back('{64'h0, 1, 0, 64'h0});
      directed.push_back('{64'hffff_ffff_ffff_ffff, 1, 0, 64'h0});
      foreach (directed[i]) send_block(directed[i].blk, directed[i].dec,
                                       directed[i].known, directed[i].want);
      drain();

      // textbook vector
      write_key(64'h1334_5779_9bbc_dff1);
      directed = {};
      directed.push_back('{64'h0123_4567_89ab_cdef, 0, 1, 64'h85e8_1354_0f0a_b405});
      directed.push_back('{64'h85e8_1354_0f0a_b405, 1, 1, 64'h0123_4567_89ab_cdef});
      directed.push_back('{64'h8000_0000_0000_0001, 0, 0, 64'h0});
      directed.push_back('{64'haaaa_aaaa_aaaa_aaaa, 1, 0, 64'h0});
      foreach (directed[i]) send_block(directed[i].blk, directed[i].dec,
                                       directed[i].known, directed[i].want);
      drain();

      // all-ones key, then weak-key pattern
      write_key(64'hffff_ffff_ffff_ffff);
      send_block(64'h0, 0, 0, 0);
      send_block(64'h5555_5555_5555_5555, 1, 0, 0);
      drain();
      write_key(64'h0101_0101_0101_0101);
      send_block(64'h0123_4567_89ab_cdef, 0, 0, 0);
      send_block(64'h0123_4567_89ab_cdef, 1, 0, 0);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 16 : (phase == 1) ? 45 : 0;
         for (int seg = 0; seg < 3; seg++) begin
            k = {$urandom, $urandom};
            write_key(k);
            for (int n = 0; n < 150; n++)
               send_block({$urandom, $urandom}, 1'($urandom_range(1)), 0, 0);
            drain();
         end
      end

      done = 1;
      if (mismatches == 0 && pending_blocks.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
